### rtl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled during reset.
`define CHK_NOW(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, disabled during reset.
`define CHK_NEXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

### rtl/bdar_pkg.sv
// Package: types and constants of the button debouncer with auto-repeat.
`default_nettype none

package bdar_pkg;

	localparam int NUM_BUTTONS = 6;
	localparam int PIN_COUNT   = 6;
	localparam int DELAY_W     = 16;
	localparam int INDEX_W     = 3;
	localparam int CFG_IDX_W   = 1;
	localparam int HIST_W      = 3;

	localparam logic [DELAY_W-1:0] RESET_FIRST_DELAY  = DELAY_W'(200);
	localparam logic [DELAY_W-1:0] RESET_REPEAT_DELAY = DELAY_W'(50);

	typedef enum logic {
		KIND_TICK = 1'b0,
		KIND_READ = 1'b1
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FIRST_DELAY  = 1'b0,
		CFG_REPEAT_DELAY = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		kind_t                kind;
		logic [PIN_COUNT-1:0] pin_levels;
		logic [INDEX_W-1:0]   button_index;
	} req_t;

	typedef struct packed {
		logic                 pressed_event;
		logic [PIN_COUNT-1:0] debounced_levels;
	} res_t;

	typedef struct packed {
		logic [DELAY_W-1:0] first_delay;
		logic [DELAY_W-1:0] repeat_delay;
	} delays_t;

	typedef struct packed {
		logic tick;
		logic sample;
		logic clear;
	} cell_ctl_t;

endpackage

`default_nettype wire

### rtl/bdar_cell.sv
// One button: sample history, debounced level, repeat countdown, event flag.
`default_nettype none

module bdar_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bdar_pkg::cell_ctl_t ctl,
	input  wire bdar_pkg::delays_t   delays,
	output logic                     level_next,
	output logic                     pending
);

	logic [bdar_pkg::HIST_W-1:0]  hist_q;
	logic                         level_q;
	logic [bdar_pkg::DELAY_W-1:0] cnt_q;
	logic                         pend_q;

	logic [bdar_pkg::HIST_W-1:0]  hist_d;
	logic                         agree;
	logic                         lvl_new;
	logic [bdar_pkg::DELAY_W-1:0] cnt_d;
	logic                         pend_d;

	always_comb begin
		hist_d     = {hist_q[bdar_pkg::HIST_W-2:0], ctl.sample};
		agree      = (hist_d == '0) || (hist_d == '1);
		lvl_new    = (hist_d == '1);
		level_next = level_q;
		cnt_d      = cnt_q;
		pend_d     = pend_q;
		if (ctl.tick && agree) begin
			if (lvl_new != level_q) begin
				level_next = lvl_new;
				if (lvl_new) begin
					cnt_d  = delays.first_delay;
					pend_d = 1'b1;
				end
			end else if (lvl_new) begin
				if (cnt_q <= bdar_pkg::DELAY_W'(1)) begin
					cnt_d  = delays.repeat_delay;
					pend_d = 1'b1;
				end else begin
					cnt_d = cnt_q - bdar_pkg::DELAY_W'(1);
				end
			end
		end
		if (ctl.clear) begin
			pend_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q  <= '0;
			level_q <= 1'b0;
			cnt_q   <= bdar_pkg::RESET_FIRST_DELAY;
			pend_q  <= 1'b0;
		end else begin
			if (ctl.tick) begin
				hist_q <= hist_d;
			end
			level_q <= level_next;
			cnt_q   <= cnt_d;
			pend_q  <= pend_d;
		end
	end

	assign pending = pend_q;

endmodule

`default_nettype wire

### rtl/button_debounce_autorepeat.sv
// Top level: request register, button cells, delay registers, result register.
// Usage:
//   Request channel (req_valid, req_stall, req): a tick request carries one raw
//   sample per button in pin_levels; a read request returns and clears the
//   press-event flag of button_index. Indexes past the last button read 0.
//   Result channel (res_valid, res_stall, res): one result per request, in
//   order, with pressed_event (0 on ticks) and the debounced levels after the
//   request has been applied.
//   A request passes the request register and then the result register, and all
//   buttons update together between the two; unless res_stall holds the result,
//   one request per cycle is taken sustained. Delay registers are written through
//   cfg_we/cfg_index/cfg_data; the user must write them only while idle, and the
//   block itself does not enforce it. Reset clears histories, levels and flags,
//   loads 200 into every countdown and sets the delays to 200 and 50. While
//   res_stall holds a result, the request register fills and req_stall then
//   rises until the result drains.
`default_nettype none

module button_debounce_autorepeat (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                req_valid,
	output logic                                     req_stall,
	input  wire bdar_pkg::req_t                      req,
	output logic                                     res_valid,
	input  wire logic                                res_stall,
	output bdar_pkg::res_t                           res,
	input  wire logic                                cfg_we,
	input  wire logic [bdar_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [bdar_pkg::DELAY_W-1:0]        cfg_data
);

	logic               valid_s1;
	bdar_pkg::req_t     req_s1;
	logic               res_valid_q;
	bdar_pkg::res_t     res_q;
	bdar_pkg::delays_t  delays_q;

	logic                             advance;
	logic                             fire;
	logic [bdar_pkg::NUM_BUTTONS-1:0] level_next;
	logic [bdar_pkg::NUM_BUTTONS-1:0] pending;
	logic [bdar_pkg::NUM_BUTTONS-1:0] read_sel;
	logic [bdar_pkg::PIN_COUNT-1:0]   levels_out;

	assign advance   = !res_valid_q || !res_stall;
	assign fire      = valid_s1 && advance;
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delays_q.first_delay  <= bdar_pkg::RESET_FIRST_DELAY;
			delays_q.repeat_delay <= bdar_pkg::RESET_REPEAT_DELAY;
		end else if (cfg_we) begin
			unique case (bdar_pkg::cfg_idx_t'(cfg_index))
				bdar_pkg::CFG_FIRST_DELAY:  delays_q.first_delay  <= cfg_data;
				bdar_pkg::CFG_REPEAT_DELAY: delays_q.repeat_delay <= cfg_data;
				default: ;
			endcase
		end
	end

	for (genvar b = 0; b < bdar_pkg::NUM_BUTTONS; b++) begin : g_btn
		bdar_pkg::cell_ctl_t ctl;

		assign read_sel[b] = (32'(req_s1.button_index) == b);
		assign ctl.tick    = fire && (req_s1.kind == bdar_pkg::KIND_TICK);
		assign ctl.clear   = fire && (req_s1.kind == bdar_pkg::KIND_READ) && read_sel[b];
		if (b < bdar_pkg::PIN_COUNT) begin : g_pin
			assign ctl.sample = req_s1.pin_levels[b];
		end else begin : g_nopin
			assign ctl.sample = 1'b0;
		end

		bdar_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.delays     (delays_q),
			.level_next (level_next[b]),
			.pending    (pending[b])
		);
	end

	for (genvar p = 0; p < bdar_pkg::PIN_COUNT; p++) begin : g_lvl
		if (p < bdar_pkg::NUM_BUTTONS) begin : g_on
			assign levels_out[p] = level_next[p];
		end else begin : g_off
			assign levels_out[p] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q.pressed_event    <= (req_s1.kind == bdar_pkg::KIND_READ) &&
				|(pending & read_sel);
			res_q.debounced_levels <= levels_out;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

### rtl/bdar_checker.sv
// Port-level checker for the button debouncer, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module bdar_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_stall,
	input wire logic           res_valid,
	input wire logic           res_stall,
	input wire bdar_pkg::res_t res
);

	`CHK_NOW(a_stall_only_backpressure, req_stall, res_valid && res_stall, "req stalled without result backpressure")
	`CHK_NOW(a_result_follows, req_valid && !req_stall, ##2 res_valid, "accepted request gave no result")
	`CHK_NEXT(a_result_holds, res_valid && res_stall, res_valid && $stable(res), "stalled result changed")

endmodule

bind button_debounce_autorepeat bdar_checker u_bdar_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

`default_nettype wire
